[hdl/tbbf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tbbf_pkg;

  localparam int HOST_PACKET_BYTES = 64;
  localparam int CHUNK_W = $clog2(HOST_PACKET_BYTES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_HOST   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_STROBE = 2'd1;
  localparam logic [1:0] KIND_BYTE   = 2'd2;

  localparam logic [3:0] HDR_FLAG   = 4'd0;
  localparam logic [3:0] HDR_LEN_LO = 4'd1;
  localparam logic [3:0] HDR_LEN_HI = 4'd2;
  localparam logic [3:0] HDR_SKIP   = 4'd3;
  localparam logic [3:0] HDR_LAST   = 4'd7;

  localparam logic [2:0] LEN_DIGITS  = 3'd5;
  localparam logic [2:0] BYTE_DIGITS = 3'd4;
  localparam logic [2:0] ONE_RESULT  = 3'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic       level;
    logic [9:0] value;
    logic [2:0] count;
    logic [7:0] read_byte;
    logic       pe;
  } cmd_t;

  function automatic logic [16:0] transfer_size(input logic [15:0] len);
    logic [16:0] size;
    if (len == 16'd1 || len == 16'd2 || len == 16'd4) begin
      size = {1'b0, len};
    end else if (len == 16'd6 || len == 16'd7) begin
      size = 17'd8;
    end else begin
      size = {1'b0, len} + 17'd8;
    end
    return size;
  endfunction

endpackage

`default_nettype wire

[hdl/two_bit_bus_bridge_framer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Turns host command packets and bus read samples into a stream of bus clocks. Each accepted
// transaction is classified by the front end, which keeps all header, transfer and read
// assembly state, and becomes at most one command in a four-entry queue. The back end emits
// one result per cycle from the queue head as long as the consumer pops them: five digits
// for the length field, four for each address or write data byte, and one for a read
// sample. A write data byte therefore takes four results; a read sample takes one and a
// dropped byte none, and input is taken back to back as long as the queue has room.
module two_bit_bus_bridge_framer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output      logic       full,
  input  wire logic       op,
  input  wire logic [7:0] host_byte,
  input  wire logic       packet_end,
  input  wire logic       bus_wait,
  input  wire logic [1:0] bus_read_digit,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [1:0] kind,
  output      logic       bus_write_level,
  output      logic [1:0] bus_digit,
  output      logic [7:0] read_byte,
  output      logic       host_packet_end,
  output      logic       last
);

  logic                          accept;
  logic                          cmd_push;
  tbbf_pkg::cmd_t                cmd;
  logic                          q_valid;
  logic                          q_pop;
  tbbf_pkg::cmd_t                q_head;
  logic [tbbf_pkg::QCNT_W-1:0]   q_count;

  assign accept = push && !full;

  tbbf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .op             (op),
    .host_byte      (host_byte),
    .packet_end     (packet_end),
    .bus_wait       (bus_wait),
    .bus_read_digit (bus_read_digit),
    .cmd_push       (cmd_push),
    .cmd            (cmd)
  );

  tbbf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .full     (full),
    .valid    (q_valid),
    .head     (q_head),
    .count    (q_count)
  );

  tbbf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .kind            (kind),
    .bus_write_level (bus_write_level),
    .bus_digit       (bus_digit),
    .read_byte       (read_byte),
    .host_packet_end (host_packet_end),
    .last            (last)
  );

  a_kind_legal : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind == tbbf_pkg::KIND_WRITE || kind == tbbf_pkg::KIND_STROBE ||
                kind == tbbf_pkg::KIND_BYTE))
    else $error("result kind out of range");

  a_strobe_last : assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != tbbf_pkg::KIND_WRITE) |-> last)
    else $error("read strobe result not marked last");

  a_strobe_clean : assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == tbbf_pkg::KIND_STROBE) |->
      (read_byte == 8'd0 && host_packet_end == 1'b0 && bus_digit == 2'd0 &&
       bus_write_level == 1'b0))
    else $error("strobe-only result carries data");

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_count <= tbbf_pkg::QCNT_W'(tbbf_pkg::QUEUE_DEPTH))
    else $error("command queue overflow");

endmodule

`default_nettype wire

[hdl/tbbf_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbbf_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic               op,
  input  wire logic [7:0]         host_byte,
  input  wire logic               packet_end,
  input  wire logic               bus_wait,
  input  wire logic [1:0]         bus_read_digit,
  output      logic               cmd_push,
  output      tbbf_pkg::cmd_t     cmd
);

  logic [3:0]                   header_position, header_position_next;
  logic                         write_flag, write_flag_next;
  logic [7:0]                   length_low, length_low_next;
  logic [16:0]                  remaining_bytes, remaining_bytes_next;
  logic                         drop_rest, drop_rest_next;
  logic [7:0]                   read_accumulator, read_accumulator_next;
  logic [1:0]                   read_digit_count, read_digit_count_next;
  logic [tbbf_pkg::CHUNK_W-1:0] read_chunk_count, read_chunk_count_next;
  logic                         has_cmd;
  logic [15:0]                  len;
  logic [7:0]                   acc_shift;

  assign len       = {host_byte, length_low};
  assign acc_shift = {bus_read_digit, read_accumulator[7:2]};

  always_comb begin
    header_position_next  = header_position;
    write_flag_next       = write_flag;
    length_low_next       = length_low;
    remaining_bytes_next  = remaining_bytes;
    drop_rest_next        = drop_rest;
    read_accumulator_next = read_accumulator;
    read_digit_count_next = read_digit_count;
    read_chunk_count_next = read_chunk_count;
    has_cmd               = 1'b0;
    cmd.kind              = tbbf_pkg::KIND_WRITE;
    cmd.level             = write_flag;
    cmd.value             = {2'b00, host_byte};
    cmd.count             = tbbf_pkg::BYTE_DIGITS;
    cmd.read_byte         = 8'd0;
    cmd.pe                = 1'b0;

    if (op == tbbf_pkg::OP_HOST) begin
      if (drop_rest) begin
        if (packet_end) begin
          drop_rest_next = 1'b0;
        end
      end else if (header_position == tbbf_pkg::HDR_FLAG && remaining_bytes != 17'd0) begin
        if (write_flag) begin
          has_cmd              = 1'b1;
          cmd.level            = 1'b1;
          remaining_bytes_next = remaining_bytes - 17'd1;
          if (remaining_bytes_next == 17'd0 && !packet_end) begin
            drop_rest_next = 1'b1;
          end
        end
      end else begin
        case (header_position)
          tbbf_pkg::HDR_FLAG: begin
            write_flag_next = (host_byte != 8'd0);
          end
          tbbf_pkg::HDR_LEN_LO: begin
            length_low_next = host_byte;
          end
          tbbf_pkg::HDR_LEN_HI: begin
            remaining_bytes_next = tbbf_pkg::transfer_size(len);
            has_cmd              = 1'b1;
            cmd.value            = len[9:0];
            cmd.count            = tbbf_pkg::LEN_DIGITS;
          end
          tbbf_pkg::HDR_SKIP: begin
          end
          default: begin
            has_cmd = 1'b1;
          end
        endcase

        if (header_position >= tbbf_pkg::HDR_LAST) begin
          header_position_next  = tbbf_pkg::HDR_FLAG;
          read_accumulator_next = 8'd0;
          read_digit_count_next = 2'd0;
          read_chunk_count_next = '0;
          if (!write_flag && !packet_end) begin
            drop_rest_next = 1'b1;
          end
        end else if (packet_end) begin
          header_position_next = tbbf_pkg::HDR_FLAG;
          remaining_bytes_next = 17'd0;
        end else begin
          header_position_next = header_position + 4'd1;
        end
      end
    end else begin
      if (header_position == tbbf_pkg::HDR_FLAG && remaining_bytes != 17'd0 && !write_flag) begin
        has_cmd   = 1'b1;
        cmd.kind  = tbbf_pkg::KIND_STROBE;
        cmd.level = 1'b0;
        cmd.value = 10'd0;
        cmd.count = tbbf_pkg::ONE_RESULT;
        if (!bus_wait) begin
          if (read_digit_count == 2'd3) begin
            cmd.kind              = tbbf_pkg::KIND_BYTE;
            cmd.read_byte         = acc_shift;
            read_accumulator_next = 8'd0;
            read_digit_count_next = 2'd0;
            remaining_bytes_next  = remaining_bytes - 17'd1;
            read_chunk_count_next = read_chunk_count + tbbf_pkg::CHUNK_W'(1);
            if (read_chunk_count_next >= tbbf_pkg::CHUNK_W'(tbbf_pkg::HOST_PACKET_BYTES) ||
                remaining_bytes_next == 17'd0) begin
              cmd.pe                = 1'b1;
              read_chunk_count_next = '0;
            end
          end else begin
            read_accumulator_next = acc_shift;
            read_digit_count_next = read_digit_count + 2'd1;
          end
        end
      end
    end
  end

  assign cmd_push = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position  <= tbbf_pkg::HDR_FLAG;
      write_flag       <= 1'b0;
      length_low       <= 8'd0;
      remaining_bytes  <= 17'd0;
      drop_rest        <= 1'b0;
      read_accumulator <= 8'd0;
      read_digit_count <= 2'd0;
      read_chunk_count <= '0;
    end else if (accept) begin
      header_position  <= header_position_next;
      write_flag       <= write_flag_next;
      length_low       <= length_low_next;
      remaining_bytes  <= remaining_bytes_next;
      drop_rest        <= drop_rest_next;
      read_accumulator <= read_accumulator_next;
      read_digit_count <= read_digit_count_next;
      read_chunk_count <= read_chunk_count_next;
    end
  end

endmodule

`default_nettype wire

[hdl/tbbf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbbf_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire tbbf_pkg::cmd_t            push_cmd,
  input  wire logic                      pop,
  output      logic                      full,
  output      logic                      valid,
  output      tbbf_pkg::cmd_t            head,
  output      logic [tbbf_pkg::QCNT_W-1:0] count
);

  tbbf_pkg::cmd_t              slots [tbbf_pkg::QUEUE_DEPTH];
  logic [tbbf_pkg::QPTR_W-1:0] wr_ptr;
  logic [tbbf_pkg::QPTR_W-1:0] rd_ptr;
  logic                        do_pop;

  assign full   = (count == tbbf_pkg::QCNT_W'(tbbf_pkg::QUEUE_DEPTH));
  assign valid  = (count != '0);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tbbf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + tbbf_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + tbbf_pkg::QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - tbbf_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/tbbf_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbbf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire tbbf_pkg::cmd_t q_head,
  output      logic           q_pop,
  input  wire logic           pop,
  output      logic           empty,
  output      logic [1:0]     kind,
  output      logic           bus_write_level,
  output      logic [1:0]     bus_digit,
  output      logic [7:0]     read_byte,
  output      logic           host_packet_end,
  output      logic           last
);

  logic       out_valid;
  logic [2:0] idx;
  logic       load;
  logic       is_last;

  assign empty   = !out_valid;
  assign load    = q_valid && (!out_valid || pop);
  assign is_last = (idx == q_head.count - 3'd1);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind            <= q_head.kind;
      bus_write_level <= q_head.level;
      bus_digit       <= q_head.value[{idx, 1'b0} +: 2];
      read_byte       <= q_head.read_byte;
      host_packet_end <= q_head.pe;
      last            <= is_last;
    end
  end

endmodule

`default_nettype wire
